/* rtl/otb_pkg.sv */
// ----------------------------------------------------------------------------
// Timer bank package
// Sizes, operation codes, the channel entry layout and the controller
// command and status words.
// ----------------------------------------------------------------------------
package otb_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int COUNT_BITS = 16;

	localparam int CNT_W     = COUNT_BITS + 1;
	localparam int CH_BITS   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int LIM_W     = $clog2(NUM_TIMERS + 1);
	localparam int OP_W      = 3;
	localparam int IN_CH_W   = 4;
	localparam int TIMEOUT_W = 16;
	localparam int OUT_CH_W  = 4;
	localparam int CFG_W     = 5;

	localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);
	localparam logic [CNT_W-1:0] CNT_DISABLED = '1;

	typedef enum logic [OP_W-1:0] {
		OP_TICK         = 3'd0,
		OP_ARM_ONESHOT  = 3'd1,
		OP_ARM_PERIODIC = 3'd2,
		OP_RELOAD       = 3'd3,
		OP_DISARM       = 3'd4
	} otb_op_t;

	typedef struct packed {
		logic                  periodic;
		logic [COUNT_BITS-1:0] period;
		logic [CNT_W-1:0]      cnt;
	} otb_entry_t;

	localparam otb_entry_t ENTRY_RESET = '{periodic: 1'b1, period: '0, cnt: '0};
	localparam int ENTRY_W = $bits(otb_entry_t);

	typedef struct packed {
		logic ready;
		logic load;
		logic rd;
		logic wr;
		logic step;
		logic flush;
	} otb_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_tick;
		logic in_chop;
		logic lim_zero;
		logic op_tick;
		logic expire;
		logic pend_valid;
		logic out_free;
		logic idx_last;
	} otb_sts_t;

endpackage

/* rtl/otb_if.sv */
// ----------------------------------------------------------------------------
// Timer bank channels
// Valid/ready interfaces for operation words and expiry words.
// ----------------------------------------------------------------------------
interface otb_in_if import otb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      op;
	logic [IN_CH_W-1:0]   channel;
	logic [TIMEOUT_W-1:0] timeout;

	modport source (output valid, output op, output channel, output timeout, input ready);
	modport sink (input valid, input op, input channel, input timeout, output ready);
endinterface

interface otb_out_if import otb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OUT_CH_W-1:0] expired_channel;
	logic                last;

	modport source (output valid, output expired_channel, output last, input ready);
	modport sink (input valid, input expired_channel, input last, output ready);
endinterface

/* rtl/oneshot_periodic_timer_bank.sv */
// ----------------------------------------------------------------------------
// One-shot and periodic timer bank
// A tick is accepted, then each active channel is read and written in turn,
// with a final expiry word when any channel expires; each expiry word waits
// while the output word is untaken. Arm, reload and disarm go through accept,
// read and write. The channel RAM, read with a registered output and then
// written once per channel, sets these steps.
// Reset clears all channels to count 0, period 0, periodic, and sets
// active_channels to 16 at once through per-channel valid bits.
// ----------------------------------------------------------------------------
module oneshot_periodic_timer_bank import otb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	otb_in_if.sink           item,
	otb_out_if.source        result
);
	otb_cmd_t cmd;
	otb_sts_t sts;

	otb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	otb_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.result    (result),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef ASSERT_OFF
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !sts.pend_valid)
		else $error("Pending expiry left behind at the end of a tick.");

	a_flush_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> (sts.out_free && sts.pend_valid))
		else $error("Final expiry word issued without room or without a pending word.");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && sts.expire && sts.pend_valid) |-> sts.out_free)
		else $error("Expiry word overwrote an untaken result.");
`endif
endmodule

/* rtl/otb_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module otb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]       wdata,
	input  logic                   re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* rtl/otb_datapath.sv */
// ----------------------------------------------------------------------------
// Timer bank datapath
// Channel storage, channel update, walk index, pending and output words.
// ----------------------------------------------------------------------------
module otb_datapath import otb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	otb_in_if.sink           item,
	otb_out_if.source        result,
	input  otb_cmd_t         cmd,
	output otb_sts_t         sts
);
	logic [CFG_W-1:0]      active_q;
	logic [LIM_W-1:0]      lim;
	logic [CH_BITS-1:0]    idx_q;
	logic [NUM_TIMERS-1:0] valid_q;
	logic                  pend_valid_q;
	logic                  out_valid_q;
	otb_op_t               op_q;
	logic [CH_BITS-1:0]    ch_q;
	logic [COUNT_BITS-1:0] t_q;
	logic                  rvalid_s2;
	logic [CH_BITS-1:0]    pend_ch_q;
	logic [OUT_CH_W-1:0]   out_ch_q;
	logic                  out_last_q;
	logic [CH_BITS-1:0]    addr;
	logic [ENTRY_W-1:0]    ram_rdata;
	otb_entry_t            cur;
	otb_entry_t            nxt;
	logic [CNT_W-1:0]      cnt_dec;
	logic                  disabled;
	logic                  expire;

	assign lim  = (32'(active_q) > NUM_TIMERS) ? LIM_W'(NUM_TIMERS) : LIM_W'(active_q);
	assign addr = (op_q == OP_TICK) ? idx_q : ch_q;

	otb_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_TIMERS)) u_ram (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (addr),
		.wdata (nxt),
		.re    (cmd.rd),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		cur      = rvalid_s2 ? otb_entry_t'(ram_rdata) : ENTRY_RESET;
		cnt_dec  = cur.cnt - CNT_W'(1);
		disabled = (cur.cnt == CNT_DISABLED);
		expire   = !disabled && (cnt_dec == '0);
		nxt      = cur;
		case (op_q)
			OP_TICK: begin
				if (!disabled) begin
					if (expire) begin
						nxt.cnt = cur.periodic ? {1'b0, cur.period} : CNT_DISABLED;
					end else begin
						nxt.cnt = cnt_dec;
					end
				end
			end
			OP_ARM_ONESHOT: begin
				nxt.cnt      = {1'b0, t_q};
				nxt.periodic = 1'b0;
			end
			OP_ARM_PERIODIC: begin
				nxt.cnt      = {1'b0, t_q};
				nxt.period   = t_q;
				nxt.periodic = 1'b1;
			end
			OP_RELOAD: begin
				nxt.cnt = cur.periodic ? {1'b0, cur.period} : CNT_DISABLED;
			end
			OP_DISARM: begin
				nxt.cnt = CNT_DISABLED;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= ACTIVE_RESET;
			idx_q        <= '0;
			valid_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			if (cmd.flush || (cmd.step && expire && pend_valid_q)) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load) begin
				idx_q <= '0;
			end
			if (cmd.wr) begin
				valid_q[addr] <= 1'b1;
			end
			if (cmd.step) begin
				idx_q <= idx_q + CH_BITS'(1);
				if (expire) begin
					pend_valid_q <= 1'b1;
				end
			end
			if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= otb_op_t'(item.op);
			ch_q <= CH_BITS'(item.channel);
			t_q  <= COUNT_BITS'(item.timeout);
		end
		if (cmd.rd) begin
			rvalid_s2 <= valid_q[addr];
		end
		if (cmd.step && expire) begin
			pend_ch_q <= idx_q;
			if (pend_valid_q) begin
				out_ch_q   <= OUT_CH_W'(pend_ch_q);
				out_last_q <= 1'b0;
			end
		end
		if (cmd.flush) begin
			out_ch_q   <= OUT_CH_W'(pend_ch_q);
			out_last_q <= 1'b1;
		end
	end

	assign item.ready             = cmd.ready;
	assign result.valid           = out_valid_q;
	assign result.expired_channel = out_ch_q;
	assign result.last            = out_last_q;

	assign sts.in_valid   = item.valid;
	assign sts.in_tick    = (item.op == OP_TICK);
	assign sts.in_chop    = ((item.op == OP_ARM_ONESHOT) || (item.op == OP_ARM_PERIODIC) ||
		(item.op == OP_RELOAD) || (item.op == OP_DISARM)) &&
		(32'(item.channel) < NUM_TIMERS);
	assign sts.lim_zero   = (lim == '0);
	assign sts.op_tick    = (op_q == OP_TICK);
	assign sts.expire     = (op_q == OP_TICK) && expire;
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free   = !out_valid_q || result.ready;
	assign sts.idx_last   = ((LIM_W'(idx_q) + LIM_W'(1)) == lim);
endmodule

/* rtl/otb_ctrl.sv */
// ----------------------------------------------------------------------------
// Timer bank controller
// Sequences the read and write of each channel and the final expiry word.
// ----------------------------------------------------------------------------
module otb_ctrl import otb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  otb_sts_t sts,
	output otb_cmd_t cmd
);
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_UPD,
		ST_FLUSH
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (sts.in_valid) begin
					cmd.load = 1'b1;
					if ((sts.in_tick && !sts.lim_zero) || sts.in_chop) begin
						state_nxt = ST_RD;
					end
				end
			end
			ST_RD: begin
				cmd.rd    = 1'b1;
				state_nxt = ST_UPD;
			end
			ST_UPD: begin
				if (!sts.op_tick) begin
					cmd.wr    = 1'b1;
					state_nxt = ST_IDLE;
				end else if (!(sts.expire && sts.pend_valid && !sts.out_free)) begin
					cmd.wr   = 1'b1;
					cmd.step = 1'b1;
					if (!sts.idx_last) begin
						state_nxt = ST_RD;
					end else if (sts.expire || sts.pend_valid) begin
						state_nxt = ST_FLUSH;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end
endmodule
